// ----- design/cnms_pkg.sv -----
// Shared types and constants of the cross-neighbour max suppression block.
package cnms_pkg;

    // Sizes of the frame, the pixels and the line stores.
    localparam int MAX_WIDTH  = 2048;
    localparam int PIXEL_BITS = 16;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = 12;
    localparam int REG_W      = 12;

    // Configuration port layout.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;
    localparam logic [REG_W-1:0] RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [REG_W-1:0] RST_IMAGE_HEIGHT = 12'd480;

    // Queue sizes between the parts.
    localparam int CMD_DEPTH  = 4;
    localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);
    localparam int OUT_DEPTH  = 4;
    localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

    // One classified input word on its way from the front to the back.
    typedef struct packed {
        logic [COL_W-1:0]      col;
        logic [PIXEL_BITS-1:0] pixel;
        logic                  emit;
        logic                  border;
        logic                  last_row;
        logic                  last_col;
    } t_cmd;

    // One decided pixel waiting in the result queue.
    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel;
        logic                  two;
        logic                  last_col;
    } t_res;

endpackage

// ----- design/cnms_front.sv -----
// Front part: column and row tracking and classification of each input word.
module cnms_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [cnms_pkg::REG_W-1:0]     i_image_width,
    input  logic [cnms_pkg::REG_W-1:0]     i_image_height,
    input  logic                           i_accept,
    input  logic [cnms_pkg::PIXEL_BITS-1:0] i_pixel_in,
    output cnms_pkg::t_cmd                 o_cmd
);

    logic [cnms_pkg::COL_W-1:0] r_col, n_col;
    logic [cnms_pkg::ROW_W-1:0] r_row, n_row;
    logic [cnms_pkg::REG_W-1:0] eff_w, eff_h, wm1, hm1;
    logic [cnms_pkg::COL_W-1:0] col;
    logic [cnms_pkg::ROW_W-1:0] row;
    logic                       last_col, last_row;

    // Clamp the frame size to the supported range.
    always_comb begin
        if (i_image_width < 12'd2) begin
            eff_w = 12'd2;
        end else if (i_image_width > cnms_pkg::REG_W'(cnms_pkg::MAX_WIDTH)) begin
            eff_w = cnms_pkg::REG_W'(cnms_pkg::MAX_WIDTH);
        end else begin
            eff_w = i_image_width;
        end
        eff_h = (i_image_height < 12'd2) ? 12'd2 : i_image_height;
        wm1   = eff_w - 12'd1;
        hm1   = eff_h - 12'd1;
    end

    // A position at or past the frame edge counts as the last column or row.
    always_comb begin
        col      = (cnms_pkg::REG_W'(r_col) < eff_w) ? r_col : cnms_pkg::COL_W'(wm1);
        row      = (cnms_pkg::REG_W'(r_row) < eff_h) ? r_row : cnms_pkg::ROW_W'(hm1);
        last_col = (cnms_pkg::REG_W'(col) == wm1);
        last_row = (cnms_pkg::REG_W'(row) == hm1);
    end

    // Classify the word: does it decide a pixel, and is that pixel on the border.
    always_comb begin
        o_cmd.col      = col;
        o_cmd.pixel    = i_pixel_in;
        o_cmd.emit     = (row != '0);
        o_cmd.border   = (row == cnms_pkg::ROW_W'(1)) || (col == '0) || last_col;
        o_cmd.last_row = last_row;
        o_cmd.last_col = last_col;
    end

    // Next raster position.
    always_comb begin
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : row + cnms_pkg::ROW_W'(1);
        end else begin
            n_col = col + cnms_pkg::COL_W'(1);
            n_row = row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ----- design/cnms_cmd_fifo.sv -----
// Short queue of classified words between the front and the back.
module cnms_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cnms_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output cnms_pkg::t_cmd o_cmd,
    output logic           o_full,
    output logic           o_empty
);

    cnms_pkg::t_cmd                 r_mem [cnms_pkg::CMD_DEPTH];
    logic [cnms_pkg::CMD_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [cnms_pkg::CMD_CNT_W-1:0] r_count;

    assign o_cmd   = r_mem[r_rd_ptr];
    assign o_full  = (r_count == cnms_pkg::CMD_CNT_W'(cnms_pkg::CMD_DEPTH));
    assign o_empty = (r_count == '0);

    // Storage; the caller never pushes when full or pops when empty.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + cnms_pkg::CMD_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + cnms_pkg::CMD_PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + cnms_pkg::CMD_CNT_W'(1);
                2'b01:   r_count <= r_count - cnms_pkg::CMD_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- design/cnms_back.sv -----
// Back part: line stores, neighbor compare and the result queue.
module cnms_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cnms_pkg::t_cmd                  i_cmd,
    input  logic                            i_cmd_empty,
    output logic                            o_cmd_pop,
    input  logic                            i_pop,
    output logic                            o_empty,
    output logic [cnms_pkg::PIXEL_BITS-1:0] o_pixel_out,
    output logic                            o_run_last,
    output logic                            o_frame_last
);

    // Line stores: row r-1 and row r-2.
    logic [cnms_pkg::PIXEL_BITS-1:0] line_prev  [cnms_pkg::MAX_WIDTH];
    logic [cnms_pkg::PIXEL_BITS-1:0] line_prev2 [cnms_pkg::MAX_WIDTH];

    logic                            r_a_valid;
    cnms_pkg::t_cmd                  r_a_cmd;
    logic [cnms_pkg::PIXEL_BITS-1:0] r_center, r_right, r_top, r_left;
    logic [cnms_pkg::COL_W-1:0]      right_addr;
    logic                            keep, res_push, res_pop;
    cnms_pkg::t_res                  res_in, res_head;

    cnms_pkg::t_res                 r_res [cnms_pkg::OUT_DEPTH];
    logic [cnms_pkg::OUT_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [cnms_pkg::OUT_CNT_W-1:0] r_count;
    logic                           r_sub;

    // Take a word only when the result queue has room for it and the one in flight.
    assign o_cmd_pop  = !i_cmd_empty &&
                        ((r_count + cnms_pkg::OUT_CNT_W'(r_a_valid)) <
                         cnms_pkg::OUT_CNT_W'(cnms_pkg::OUT_DEPTH));
    assign right_addr = i_cmd.col + cnms_pkg::COL_W'(1);

    // Row r-1 store: read the center and right neighbor, then store the new pixel.
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_center              <= line_prev[i_cmd.col];
            r_right               <= line_prev[right_addr];
            line_prev[i_cmd.col]  <= i_cmd.pixel;
        end
    end

    // Row r-2 store: read the top neighbor; the decided center moves down a row.
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_top <= line_prev2[i_cmd.col];
        end
        if (r_a_valid) begin
            line_prev2[r_a_cmd.col] <= r_center;
        end
    end

    // The left neighbor is the center decided one word earlier.
    always_ff @(posedge i_clk) begin
        if (r_a_valid) begin
            r_left <= r_center;
        end
        if (o_cmd_pop) begin
            r_a_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= o_cmd_pop;
        end
    end

    // Strict local maximum over the four neighbors.
    always_comb begin
        keep = !r_a_cmd.border &&
               (r_center > r_left) && (r_center > r_right) &&
               (r_center > r_top)  && (r_center > r_a_cmd.pixel);
        res_in.pixel    = keep ? r_center : '0;
        res_in.two      = r_a_cmd.last_row;
        res_in.last_col = r_a_cmd.last_col;
        res_push        = r_a_valid && r_a_cmd.emit;
    end

    // Result queue; an entry of the last row yields a second, zero word.
    assign res_head     = r_res[r_rd_ptr];
    assign o_empty      = (r_count == '0);
    assign o_pixel_out  = r_sub ? '0 : res_head.pixel;
    assign o_run_last   = r_sub || !res_head.two;
    assign o_frame_last = r_sub && res_head.last_col;
    assign res_pop      = i_pop && !o_empty && (r_sub || !res_head.two);

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_res[r_wr_ptr] <= res_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_sub    <= 1'b0;
        end else begin
            if (res_push) begin
                r_wr_ptr <= r_wr_ptr + cnms_pkg::OUT_PTR_W'(1);
            end
            if (res_pop) begin
                r_rd_ptr <= r_rd_ptr + cnms_pkg::OUT_PTR_W'(1);
            end
            if (i_pop && !o_empty) begin
                r_sub <= res_head.two && !r_sub;
            end
            case ({res_push, res_pop})
                2'b10:   r_count <= r_count + cnms_pkg::OUT_CNT_W'(1);
                2'b01:   r_count <= r_count - cnms_pkg::OUT_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- design/cross_neighbour_max_suppression_top.sv -----
// Top level of the cross-neighbour max suppression block with its register port.
//
// The block takes one pixel word per clock while full is low and, once the
// pipeline has filled, gives one result word per clock while pop is held; a
// pixel in the last row gives two result words. A pixel passes through the
// command queue, the registered read of the line stores and the result queue;
// the row r-1 store is read twice and written once for each pixel. Pixels of
// row 0 give no result. The line stores are not cleared after reset; the first
// frame writes each entry before a value read from it can affect a result.
// Change the frame size only while the block is idle.
module cross_neighbour_max_suppression_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [cnms_pkg::PIXEL_BITS-1:0]   i_pixel_in,
    input  logic                              pop,
    output logic                              empty,
    output logic [cnms_pkg::PIXEL_BITS-1:0]   o_pixel_out,
    output logic                              o_run_last,
    output logic                              o_frame_last,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cnms_pkg::PADDR_W-1:0]      paddr,
    input  logic [cnms_pkg::PDATA_W-1:0]      pwdata,
    output logic [cnms_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    logic [cnms_pkg::REG_W-1:0] r_image_width, r_image_height;
    logic                       cfg_wr, in_accept, cmd_pop, cmd_empty;
    cnms_pkg::t_cmd             front_cmd, back_cmd;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= cnms_pkg::RST_IMAGE_WIDTH;
            r_image_height <= cnms_pkg::RST_IMAGE_HEIGHT;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                cnms_pkg::REG_IMAGE_WIDTH:  r_image_width  <= pwdata[cnms_pkg::REG_W-1:0];
                cnms_pkg::REG_IMAGE_HEIGHT: r_image_height <= pwdata[cnms_pkg::REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            cnms_pkg::REG_IMAGE_WIDTH:  prdata = cnms_pkg::PDATA_W'(r_image_width);
            cnms_pkg::REG_IMAGE_HEIGHT: prdata = cnms_pkg::PDATA_W'(r_image_height);
            default:                    prdata = '0;
        endcase
    end

    // Front, command queue and back.
    assign in_accept = push && !full;

    cnms_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .i_accept       (in_accept),
        .i_pixel_in     (i_pixel_in),
        .o_cmd          (front_cmd)
    );

    cnms_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_cmd   (front_cmd),
        .i_pop   (cmd_pop),
        .o_cmd   (back_cmd),
        .o_full  (full),
        .o_empty (cmd_empty)
    );

    cnms_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (back_cmd),
        .i_cmd_empty  (cmd_empty),
        .o_cmd_pop    (cmd_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_pixel_out  (o_pixel_out),
        .o_run_last   (o_run_last),
        .o_frame_last (o_frame_last)
    );

    // Reset leaves both queues empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    // The end of a frame is a border word that closes its run.
    a_frame_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_frame_last |-> o_run_last && (o_pixel_out == '0))
        else $error("frame end word malformed");

    // Taking the first word of a pair leaves its zero partner waiting.
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !empty && !o_run_last |=> !empty && o_run_last && (o_pixel_out == '0))
        else $error("second word of a pair missing");

endmodule

// ----- tb/tb_cross_neighbour_max_suppression_top.sv -----
// Testbench of the cross-neighbor max suppression block.
module tb_cross_neighbour_max_suppression_top;

    localparam int          PB          = cnms_pkg::PIXEL_BITS;
    localparam int unsigned CYCLE_LIMIT = 600_000;
    localparam int unsigned RANDOM_WORDS = 1450;
    localparam int unsigned SETTLE_CYCLES = 10;

    // Ways of filling a frame with magnitudes.
    typedef enum int {
        PAT_FULL,
        PAT_FLAT,
        PAT_EXTREME,
        PAT_PEAKS
    } t_fill_kind;

    // One decided pixel as the block should deliver it.
    typedef struct packed {
        logic [PB-1:0] pixel;
        logic          run_last;
        logic          frame_last;
    } t_nms_word;

    // Tracks the frame position and the two line stores, and predicts the decided pixels.
    class t_nms_tracker;
        logic [PB-1:0]           line_above  [cnms_pkg::MAX_WIDTH];
        logic [PB-1:0]           line_above2 [cnms_pkg::MAX_WIDTH];
        int unsigned             col_pos;
        int unsigned             row_pos;
        logic [cnms_pkg::REG_W-1:0] width_reg;
        logic [cnms_pkg::REG_W-1:0] height_reg;
        t_nms_word               awaited_words [$];
        int unsigned             errors;
        int unsigned             words_seen;

        function new();
            foreach (line_above[i]) begin
                line_above[i]  = '0;
                line_above2[i] = '0;
            end
            col_pos    = 0;
            row_pos    = 0;
            width_reg  = cnms_pkg::RST_IMAGE_WIDTH;
            height_reg = cnms_pkg::RST_IMAGE_HEIGHT;
            errors     = 0;
            words_seen = 0;
        endfunction

        // A register write lands at once; only the low 12 bits are kept.
        function void write_size(logic idx, logic [31:0] value);
            if (idx == cnms_pkg::REG_IMAGE_WIDTH) begin
                width_reg = value[cnms_pkg::REG_W-1:0];
            end else begin
                height_reg = value[cnms_pkg::REG_W-1:0];
            end
        endfunction

        // An accepted pixel decides the pixel one row up in the same column.
        function void take_pixel(logic [PB-1:0] px);
            int unsigned w, h, c, r;
            logic [PB-1:0] center, north, west, east;
            bit last_col, last_row, border, keep;
            t_nms_word word;
            w = width_reg;
            if (w < 2) w = 2;
            if (w > cnms_pkg::MAX_WIDTH) w = cnms_pkg::MAX_WIDTH;
            h = (height_reg < 2) ? 2 : height_reg;
            c = (col_pos < w) ? col_pos : w - 1;
            r = (row_pos < h) ? row_pos : h - 1;
            last_col = (c == w - 1);
            last_row = (r == h - 1);

            // The left neighbor was already moved into the older store this row.
            center = line_above[c];
            north  = line_above2[c];
            west   = (c > 0) ? line_above2[c-1] : '0;
            east   = (c + 1 < w) ? line_above[c+1] : '0;
            line_above2[c] = center;
            line_above[c]  = px;

            if (r >= 1) begin
                border = (r == 1) || (c == 0) || last_col;
                keep = !border && center > west && center > east &&
                       center > north && center > px;
                word.pixel      = keep ? center : '0;
                word.run_last   = !last_row;
                word.frame_last = 1'b0;
                awaited_words.push_back(word);
                // The last row also gives the zero of its own border pixel.
                if (last_row) begin
                    word.pixel      = '0;
                    word.run_last   = 1'b1;
                    word.frame_last = last_col;
                    awaited_words.push_back(word);
                end
            end

            if (last_col) begin
                col_pos = 0;
                row_pos = last_row ? 0 : r + 1;
            end else begin
                col_pos = c + 1;
                row_pos = r;
            end
        endfunction

        // Compares a delivered word with the oldest prediction.
        function void check_word(logic [PB-1:0] pix, logic rl, logic fl);
            t_nms_word want;
            words_seen++;
            if (awaited_words.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("word %0d unexpected: pixel %0d run_last %0b frame_last %0b",
                             words_seen, pix, rl, fl);
                end
                return;
            end
            want = awaited_words.pop_front();
            if (want.pixel !== pix || want.run_last !== rl || want.frame_last !== fl) begin
                errors++;
                if (errors <= 10) begin
                    $display("word %0d: exp %0d/%0b/%0b got %0d/%0b/%0b",
                             words_seen, want.pixel, want.run_last, want.frame_last,
                             pix, rl, fl);
                end
            end
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          push = 1'b0;
    logic                          full;
    logic [PB-1:0]                 i_pixel_in = '0;
    logic                          pop = 1'b0;
    logic                          empty;
    logic [PB-1:0]                 o_pixel_out;
    logic                          o_run_last;
    logic                          o_frame_last;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [cnms_pkg::PADDR_W-1:0]  paddr = '0;
    logic [cnms_pkg::PDATA_W-1:0]  pwdata = '0;
    logic [cnms_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;

    t_nms_tracker tracker;
    int unsigned cycles = 0;
    int unsigned stall_left = 0;
    int unsigned pixel_count = 0;
    int unsigned frame_w = 2;
    int unsigned frame_h = 2;
    bit          send_idle = 1'b1;
    bit          take_idle = 1'b1;
    bit          calm = 1'b0;

    // Directed frame: one kept maximum, neighbors that tie, and both pixel extremes.
    logic [PB-1:0] demo_frame [16] = '{
        16'd0,     16'd1000,  16'd7,   16'd3,
        16'd9,     16'd65535, 16'd100, 16'd2,
        16'd1,     16'd50,    16'd100, 16'd5,
        16'd65535, 16'd0,     16'd4,   16'd0
    };

    cross_neighbour_max_suppression_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_pixel_in   (i_pixel_in),
        .pop          (pop),
        .empty        (empty),
        .o_pixel_out  (o_pixel_out),
        .o_run_last   (o_run_last),
        .o_frame_last (o_frame_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 i_clk = ~i_clk;

    // Stops a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: check each accepted word, then choose pop for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            tracker.check_word(o_pixel_out, o_run_last, o_frame_last);
        end
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            pop <= 1'b0;
        end else if (take_idle && !calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    function automatic logic [PB-1:0] pick_pixel(t_fill_kind kind);
        case (kind)
            PAT_FULL:    return PB'($urandom_range(0, 65535));
            PAT_FLAT:    return PB'($urandom_range(0, 3));
            PAT_EXTREME: return ($urandom_range(0, 1) == 1) ? '1 : '0;
            default: begin
                if ($urandom_range(0, 7) == 0) begin
                    return PB'($urandom_range(0, 65535));
                end
                return PB'($urandom_range(0, 15));
            end
        endcase
    endfunction

    // Offers one pixel until it is taken, then maybe idles for a burst.
    task automatic send_pixel(logic [PB-1:0] pix);
        push       <= 1'b1;
        i_pixel_in <= pix;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        tracker.take_pixel(pix);
        pixel_count++;
        if (send_idle && !calm && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // Waits until every predicted word is out, then lets the pipeline settle.
    task automatic drain();
        push <= 1'b0;
        while (tracker.awaited_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [cnms_pkg::REG_W-1:0] value);
        logic [cnms_pkg::PDATA_W-1:0] data;
        data = $urandom;
        data[cnms_pkg::REG_W-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tracker.write_size(idx, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Writes both size registers once the block has gone quiet.
    task automatic set_frame_size(logic [cnms_pkg::REG_W-1:0] w, logic [cnms_pkg::REG_W-1:0] h);
        drain();
        write_reg(cnms_pkg::REG_IMAGE_WIDTH, w);
        write_reg(cnms_pkg::REG_IMAGE_HEIGHT, h);
        frame_w = (w < 2) ? 2 : ((w > cnms_pkg::MAX_WIDTH) ? cnms_pkg::MAX_WIDTH : w);
        frame_h = (h < 2) ? 2 : h;
    endtask

    task automatic send_frame(t_fill_kind kind);
        repeat (frame_w * frame_h) send_pixel(pick_pixel(kind));
    endtask

    // Sends pixels until the raster position wraps back to the frame start.
    task automatic finish_frame(t_fill_kind kind);
        do begin
            send_pixel(pick_pixel(kind));
        end while (tracker.col_pos != 0 || tracker.row_pos != 0);
    endtask

    // A random size, mostly small, now and then below the legal range.
    task automatic random_phase();
        int unsigned pick;
        logic [cnms_pkg::REG_W-1:0] w, h;
        pick = $urandom_range(0, 19);
        if (pick == 0) w = cnms_pkg::REG_W'($urandom_range(0, 1));
        else if (pick < 3) w = cnms_pkg::REG_W'($urandom_range(17, 64));
        else w = cnms_pkg::REG_W'($urandom_range(2, 16));
        pick = $urandom_range(0, 19);
        if (pick == 0) h = cnms_pkg::REG_W'($urandom_range(0, 1));
        else if (pick < 3) h = cnms_pkg::REG_W'($urandom_range(9, 24));
        else h = cnms_pkg::REG_W'($urandom_range(2, 8));
        send_idle = ($urandom_range(0, 3) != 0);
        take_idle = ($urandom_range(0, 3) != 0);
        set_frame_size(w, h);
        repeat ($urandom_range(1, 2)) send_frame(t_fill_kind'($urandom_range(0, 3)));
    endtask

    initial begin
        tracker = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frame with a known maximum and tied neighbors.
        set_frame_size(4, 4);
        foreach (demo_frame[i]) send_pixel(demo_frame[i]);

        // Shrink the frame while the counters sit past the new size.
        repeat (11) send_pixel(pick_pixel(PAT_FULL));
        set_frame_size(1, 0);
        send_pixel('1);

        // Random frames with idling on both sides.
        while (pixel_count < RANDOM_WORDS) random_phase();

        // Sizes above and below the legal range, cut short by a shrink, all at full rate.
        calm = 1'b1;
        set_frame_size(4095, 0);
        repeat (40) send_pixel(pick_pixel(PAT_FULL));
        set_frame_size(2, 2);
        finish_frame(PAT_PEAKS);
        set_frame_size(2, 4095);
        repeat (40) send_pixel(pick_pixel(PAT_FULL));
        set_frame_size(2, 2);
        finish_frame(PAT_FULL);
        repeat (3) random_phase();

        drain();
        if (tracker.errors == 0 && tracker.awaited_words.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
